// File: sv/kywa_pkg.sv
package kywa_pkg;

	localparam int TYPES_DEF  = 10;
	localparam int WINDOW_DEF = 10;

	// Shared divider: 32-bit dividend, 9-bit divisor.
	localparam int DIV_W = 32;
	localparam int DVS_W = 9;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	typedef struct packed {
		logic        tag_v;
		logic [15:0] tag_year;
		logic [16:0] stress;
		logic [23:0] uptake;
	} ring_word_t;

	localparam int RING_W = $bits(ring_word_t);

	typedef enum logic [12:0] {
		ST_IDLE   = 13'b0000000000001,
		ST_SEARCH = 13'b0000000000010,
		ST_DIVY   = 13'b0000000000100,
		ST_WAITY  = 13'b0000000001000,
		ST_DIVR   = 13'b0000000010000,
		ST_WAITR  = 13'b0000000100000,
		ST_SCAN   = 13'b0000001000000,
		ST_DRAIN  = 13'b0000010000000,
		ST_AVGS   = 13'b0000100000000,
		ST_WAITS  = 13'b0001000000000,
		ST_AVGU   = 13'b0010000000000,
		ST_WAITU  = 13'b0100000000000,
		ST_DONE   = 13'b1000000000000
	} state_t;

endpackage

// File: sv/kywa_mem.sv
module kywa_mem #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 10,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// File: sv/kywa_div.sv
module kywa_div
	import kywa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	localparam int CW = $clog2(DIV_W);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DIV_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             qbit;

	// One restoring step per cycle; quotient bits shift in behind the dividend.
	always_comb begin
		trial = {rem_q, dvd_q[DIV_W-1]};
		qbit  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DIV_W-2:0], qbit};
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// File: sv/keyed_ten_year_window_averager.sv
// One request is worked at a time and busy stays high until its result, so a new
// request is taken only after it. The work is three passes through the shared
// 32-step divider (the ratio, skipped when stress_days is zero, and two averages),
// the type search and the ring scan, one entry a cycle. A zero crop_code, or a new
// type with the type table full, ends at done without the passes or the scan.
// The result is shown for one cycle with done; the receiver cannot stall.
// Reset empties the type table at once; a ring row is swept when its type is new.
module keyed_ten_year_window_averager
	import kywa_pkg::*;
#(
	parameter int NUM_TYPES    = TYPES_DEF,
	parameter int WINDOW_YEARS = WINDOW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        first_in_year,
	input  logic [15:0] sim_year,
	input  logic [7:0]  crop_code,
	input  logic [31:0] stress_total,
	input  logic [8:0]  stress_days,
	input  logic [23:0] uptake,
	output logic        done,
	output logic [3:0]  type_slot,
	output logic [16:0] avg_stress,
	output logic [23:0] avg_uptake,
	output logic [3:0]  valid_years,
	output logic        status
);

	localparam int DEPTH  = NUM_TYPES * WINDOW_YEARS;
	localparam int RAW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TYPE_W = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
	localparam int FC_W   = $clog2(NUM_TYPES + 1);
	localparam int SI_W   = $clog2(WINDOW_YEARS);
	localparam int CNT_W  = $clog2(WINDOW_YEARS + 1);
	localparam int SS_W   = 17 + CNT_W;
	localparam int SU_W   = 24 + CNT_W;
	// Reciprocal of the window length, exact for every 16-bit year.
	localparam int          YK = 16 + $clog2(WINDOW_YEARS);
	localparam logic [23:0] YM = 24'(((64'd1 << YK) + 64'(WINDOW_YEARS) - 64'd1) /
		64'(WINDOW_YEARS));

	state_t state_q;

	logic [15:0] year_q;
	logic [7:0]  code_q;
	logic [31:0] total_q;
	logic [8:0]  days_q;
	logic [23:0] upt_q;

	logic [FC_W-1:0]   fc_q;
	logic [FC_W-1:0]   idx_q;
	logic [TYPE_W-1:0] idx_s1;
	logic              vld_s1;
	logic [TYPE_W-1:0] type_q;
	logic              newrow_q;
	logic [SI_W-1:0]   slot_q;
	logic [15:0]       yquo_q;
	logic [16:0]       ratio_q;
	logic [SI_W-1:0]   scan_q;
	logic              new_s1;
	logic              mem_s1;
	logic [SS_W-1:0]   sum_s_q;
	logic [SU_W-1:0]   sum_u_q;
	logic [CNT_W-1:0]  cnt_q;

	logic [TYPE_W-1:0] type_o_q;
	logic [16:0]       avg_s_q;
	logic [23:0]       avg_u_q;
	logic [CNT_W-1:0]  cnt_o_q;
	logic              status_q;

	// Type table memory.
	logic              tt_en;
	logic              tt_we;
	logic [TYPE_W-1:0] tt_addr;
	logic [7:0]        tt_rdata;

	// Ring memory.
	logic              rg_en;
	logic              rg_we;
	logic [RAW-1:0]    rg_addr;
	ring_word_t        rg_wword;
	logic [RING_W-1:0] rg_rdata;
	ring_word_t        rg_rword;

	// Divider.
	logic             div_go;
	logic [DIV_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic             div_done;
	logic [DIV_W-1:0] div_q;

	logic [RAW-1:0] base;
	logic           accept;
	logic           hit;
	logic           search_end;
	logic           qualifies;
	logic [31:0]    type_wide;
	logic [31:0]    cnt_wide;
	logic [39:0]    yprod;
	logic [15:0]    yrem;

	assign accept     = start && state_q == ST_IDLE;
	assign busy       = state_q != ST_IDLE;
	assign done       = state_q == ST_DONE;
	assign base       = RAW'(type_q * WINDOW_YEARS);
	assign hit        = vld_s1 && tt_rdata == code_q;
	assign search_end = !vld_s1 && idx_q == fc_q;
	assign rg_rword   = ring_word_t'(rg_rdata);
	assign qualifies  = rg_rword.tag_v &&
		({2'b00, rg_rword.tag_year} + 18'(WINDOW_YEARS - 1)) >= {2'b00, year_q};
	assign yprod      = 40'(year_q) * 40'(YM);
	assign yrem       = year_q - 16'(32'(yquo_q) * 32'(WINDOW_YEARS));

	always_comb begin
		tt_en   = 1'b0;
		tt_we   = 1'b0;
		tt_addr = idx_q[TYPE_W-1:0];
		if (state_q == ST_SEARCH) begin
			if (!hit && search_end && fc_q != FC_W'(NUM_TYPES)) begin
				tt_en   = 1'b1;
				tt_we   = 1'b1;
				tt_addr = fc_q[TYPE_W-1:0];
			end else if (!hit && idx_q != fc_q) begin
				tt_en = 1'b1;
			end
		end
	end

	always_comb begin
		rg_en    = 1'b0;
		rg_we    = 1'b0;
		rg_addr  = base + RAW'(scan_q);
		rg_wword = '0;
		if (state_q == ST_SCAN) begin
			rg_en = 1'b1;
			if (scan_q == slot_q) begin
				rg_we             = 1'b1;
				rg_wword.tag_v    = 1'b1;
				rg_wword.tag_year = year_q;
				rg_wword.stress   = ratio_q;
				rg_wword.uptake   = upt_q;
			end else if (newrow_q) begin
				// A freshly inserted type owns a row of stale entries.
				rg_we = 1'b1;
			end
		end
	end

	always_comb begin
		div_go  = 1'b0;
		div_dvd = '0;
		div_dvs = '0;
		unique case (state_q)
			ST_DIVR: begin
				div_go  = 1'b1;
				div_dvd = total_q;
				div_dvs = days_q;
			end
			ST_AVGS: begin
				div_go  = 1'b1;
				div_dvd = DIV_W'(sum_s_q);
				div_dvs = DVS_W'(cnt_q);
			end
			ST_AVGU: begin
				div_go  = 1'b1;
				div_dvd = DIV_W'(sum_u_q);
				div_dvs = DVS_W'(cnt_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fc_q    <= '0;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
			new_s1  <= 1'b0;
			mem_s1  <= 1'b0;
		end else begin
			new_s1 <= 1'b0;
			mem_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idx_q  <= '0;
						vld_s1 <= 1'b0;
						if (first_in_year && sim_year == 16'd1) begin
							fc_q <= '0;
						end
						state_q <= (crop_code == 8'd0) ? ST_DONE : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						state_q <= ST_DIVY;
					end else if (search_end) begin
						if (fc_q != FC_W'(NUM_TYPES)) begin
							fc_q    <= fc_q + 1'b1;
							state_q <= ST_DIVY;
						end else begin
							state_q <= ST_DONE;
						end
					end else begin
						vld_s1 <= tt_en;
						if (tt_en) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				ST_DIVY: state_q <= ST_WAITY;
				ST_WAITY: state_q <= (days_q == 9'd0) ? ST_SCAN : ST_DIVR;
				ST_DIVR: state_q <= ST_WAITR;
				ST_WAITR: begin
					if (div_done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					new_s1 <= scan_q == slot_q;
					mem_s1 <= scan_q != slot_q && !newrow_q;
					if (scan_q == SI_W'(WINDOW_YEARS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_AVGS;
				ST_AVGS:  state_q <= ST_WAITS;
				ST_WAITS: begin
					if (div_done) begin
						state_q <= ST_AVGU;
					end
				end
				ST_AVGU: state_q <= ST_WAITU;
				ST_WAITU: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			year_q   <= sim_year;
			code_q   <= crop_code;
			total_q  <= stress_total;
			days_q   <= stress_days;
			upt_q    <= uptake;
			ratio_q  <= ONE_Q16;
			status_q <= 1'b1;
			type_o_q <= '0;
			avg_s_q  <= ONE_Q16;
			avg_u_q  <= '0;
			cnt_o_q  <= '0;
		end
		if (state_q == ST_SEARCH) begin
			idx_s1 <= idx_q[TYPE_W-1:0];
			if (hit) begin
				type_q   <= idx_s1;
				newrow_q <= 1'b0;
			end else if (search_end) begin
				type_q   <= fc_q[TYPE_W-1:0];
				newrow_q <= 1'b1;
			end
		end
		if (state_q == ST_DIVY) begin
			yquo_q <= yprod[YK +: 16];
		end
		if (state_q == ST_WAITY) begin
			slot_q <= yrem[SI_W-1:0];
		end
		if (state_q == ST_WAITR && div_done) begin
			ratio_q <= (div_q > DIV_W'(ONE_Q16)) ? ONE_Q16 : div_q[16:0];
		end
		if (state_q == ST_SCAN) begin
			scan_q <= scan_q + 1'b1;
		end else begin
			scan_q <= '0;
		end
		if (state_q == ST_DIVY) begin
			sum_s_q <= '0;
			sum_u_q <= '0;
			cnt_q   <= '0;
		end else if (new_s1) begin
			sum_s_q <= sum_s_q + SS_W'(ratio_q);
			sum_u_q <= sum_u_q + SU_W'(upt_q);
			cnt_q   <= cnt_q + 1'b1;
		end else if (mem_s1 && qualifies) begin
			sum_s_q <= sum_s_q + SS_W'(rg_rword.stress);
			sum_u_q <= sum_u_q + SU_W'(rg_rword.uptake);
			cnt_q   <= cnt_q + 1'b1;
		end
		// The last ring entry is summed at the end of the drain cycle.
		if (state_q == ST_AVGS) begin
			status_q <= 1'b0;
			type_o_q <= type_q;
			cnt_o_q  <= cnt_q;
		end
		if (state_q == ST_WAITS && div_done) begin
			avg_s_q <= div_q[16:0];
		end
		if (state_q == ST_WAITU && div_done) begin
			avg_u_q <= div_q[23:0];
		end
	end

	assign type_wide   = 32'(type_o_q);
	assign cnt_wide    = 32'(cnt_o_q);
	assign type_slot   = type_wide[3:0];
	assign valid_years = cnt_wide[3:0];
	assign avg_stress  = avg_s_q;
	assign avg_uptake  = avg_u_q;
	assign status      = status_q;

	kywa_mem #(
		.WIDTH (8),
		.DEPTH (NUM_TYPES),
		.AW    (TYPE_W)
	) u_types (
		.clk   (clk),
		.en    (tt_en),
		.we    (tt_we),
		.addr  (tt_addr),
		.wdata (code_q),
		.rdata (tt_rdata)
	);

	kywa_mem #(
		.WIDTH (RING_W),
		.DEPTH (DEPTH),
		.AW    (RAW)
	) u_ring (
		.clk   (clk),
		.en    (rg_en),
		.we    (rg_we),
		.addr  (rg_addr),
		.wdata (rg_wword),
		.rdata (rg_rdata)
	);

	kywa_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (div_go),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.done      (div_done),
		.quotient  (div_q)
	);

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FC_W'(NUM_TYPES))
		else $error("type table fill count exceeds its depth");

	a_drop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && status |-> valid_years == 4'd0 && avg_stress == ONE_Q16 && avg_uptake == 24'd0)
		else $error("dropped request carries window data");

	a_stored_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done && !status |-> cnt_o_q != '0)
		else $error("stored request found an empty window");

	a_scan_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |-> $past(state_q) == ST_SCAN && !div_done)
		else $error("ring scan ended out of order");
`endif

endmodule
